// ===== rtl/core/sync_framed_packet_receiver_assert.svh =====
// assertion macros shared by the deframer modules
`ifndef SYNC_FRAMED_PACKET_RECEIVER_ASSERT_SVH
`define SYNC_FRAMED_PACKET_RECEIVER_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define SFPR_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define SFPR_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/sfpr_pkg.sv =====
// shared types, constants and helpers of the packet deframer
package sfpr_pkg;

   localparam int PAYLOAD_LIMIT_DEFAULT = 32;
   localparam logic [7:0] SYNC_RESET = 8'hAA;
   localparam logic [8:0] MOD_BASE = 9'h0FF;
   localparam int STORE_DEPTH = 31;
   localparam int IDX_W = 5;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic {
      OP_BYTE    = 1'b0,
      OP_TIMEOUT = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      PH_SYNC1,
      PH_SYNC2,
      PH_HEADER,
      PH_LENGTH,
      PH_DATA,
      PH_CHECK
   } phase_type;

   // one accepted packet waiting to drain
   typedef struct packed {
      logic [7:0]       header;
      logic [IDX_W-1:0] length;
      logic             bank;
   } desc_type;

   // payload store write from the parser
   typedef struct packed {
      logic             en;
      logic             bank;
      logic [IDX_W-1:0] index;
      logic [7:0]       data;
   } store_wr_type;

   // result word fields minus the payload byte
   typedef struct packed {
      logic [7:0]       header;
      logic [IDX_W-1:0] length;
      logic [IDX_W-1:0] pos;
      logic             has;
      logic             last;
   } rsp_meta_type;

   // add modulo 255, a + b stays at or below 510
   function automatic logic [7:0] add_mod255(logic [7:0] a, logic [7:0] b);
      logic [8:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= MOD_BASE) begin
         s = s - MOD_BASE;
      end
      return s[7:0];
   endfunction

endpackage

// ===== rtl/core/sfpr_if.sv =====
// valid/ready channel interfaces of the packet deframer

// received byte or timeout word
interface sfpr_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] rx_byte;
   modport source (output valid, output operation, output rx_byte, input ready);
   modport sink (input valid, input operation, input rx_byte, output ready);
endinterface

// one result word of a packet run
interface sfpr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] header_byte;
   logic [4:0] payload_length;
   logic [4:0] byte_position;
   logic [7:0] payload_byte;
   logic       has_payload;
   logic       last_of_packet;
   modport source (output valid, output header_byte, output payload_length,
                   output byte_position, output payload_byte, output has_payload,
                   output last_of_packet, input ready);
   modport sink (input valid, input header_byte, input payload_length,
                 input byte_position, input payload_byte, input has_payload,
                 input last_of_packet, output ready);
endinterface

// sync value register write
interface sfpr_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] sync_value;
   modport source (output valid, output sync_value, input ready);
   modport sink (input valid, input sync_value, output ready);
endinterface

// ===== rtl/core/sync_framed_packet_receiver.sv =====
// Output path: with the drain side idle, a good packet passes the packet queue, the read stage
//   and the result register in that order; words follow one per cycle on rsp_ch.ready
// Throughput: one input word per cycle; input stalls only while two committed packets are
//   still being read out of the two-bank payload store (two-entry packet queue).
// Reset: synchronous, active high; clears the parser, queue and output valid, sets the sync
//   value to 0xAA; the payload store is not cleared and needs no clearing pass.
module sync_framed_packet_receiver #(
   parameter int PAYLOAD_LIMIT = sfpr_pkg::PAYLOAD_LIMIT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   sfpr_req_if.sink    req_ch,
   sfpr_rsp_if.source  rsp_ch,
   sfpr_csr_if.sink    csr_ch
);
   import sfpr_pkg::*;

   logic [7:0]   sync_ff;
   store_wr_type store_wr;
   logic         push;
   desc_type     push_desc;
   desc_type     head;
   logic         head_valid;
   logic         q_full;
   logic         pop;

   // sync value register, always writable
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= SYNC_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         sync_ff <= csr_ch.sync_value;
      end
   end

   // frame parser
   sfpr_front #(
      .PAYLOAD_LIMIT (PAYLOAD_LIMIT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .sync_value (sync_ff),
      .q_full     (q_full),
      .store_wr   (store_wr),
      .push       (push),
      .push_desc  (push_desc)
   );

   // committed packet queue
   sfpr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_desc  (push_desc),
      .pop        (pop),
      .head       (head),
      .head_valid (head_valid),
      .full       (q_full)
   );

   // drain engine
   sfpr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .rsp_ch     (rsp_ch),
      .store_wr   (store_wr),
      .head       (head),
      .head_valid (head_valid),
      .pop        (pop)
   );

endmodule

// ===== rtl/core/sfpr_front.sv =====
// frame parser: sync hunt, header, length, payload capture, checksum
module sfpr_front #(
   parameter int PAYLOAD_LIMIT = sfpr_pkg::PAYLOAD_LIMIT_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   sfpr_req_if.sink              req_ch,
   input  logic [7:0]            sync_value,
   input  logic                  q_full,
   output sfpr_pkg::store_wr_type store_wr,
   output logic                  push,
   output sfpr_pkg::desc_type    push_desc
);
   import sfpr_pkg::*;

   phase_type        phase_ff, phase_in;
   logic [7:0]       header_ff, header_in;
   logic [IDX_W-1:0] length_ff, length_in;
   logic [IDX_W-1:0] count_ff, count_in;
   logic [7:0]       sum_ff, sum_in;
   logic             bank_ff, bank_in;
   logic             accept;
   logic             len_ok;

   // both store banks busy blocks new words
   assign req_ch.ready = !q_full;
   assign accept = req_ch.valid && req_ch.ready;
   assign len_ok = (int'(req_ch.rx_byte) < PAYLOAD_LIMIT) &&
                   (int'(req_ch.rx_byte) <= STORE_DEPTH);
   assign push_desc = '{header: header_ff, length: length_ff, bank: bank_ff};

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SYNC1;
         header_ff <= '0;
         length_ff <= '0;
         count_ff  <= '0;
         sum_ff    <= '0;
         bank_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         header_ff <= header_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         bank_ff   <= bank_in;
      end
   end

   // next state, store write and packet commit
   always_comb begin
      phase_in  = phase_ff;
      header_in = header_ff;
      length_in = length_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      bank_in   = bank_ff;
      push      = 1'b0;
      store_wr  = '{en: 1'b0, bank: bank_ff, index: count_ff, data: req_ch.rx_byte};
      if (accept) begin
         if (req_ch.operation == OP_TIMEOUT) begin
            phase_in = PH_SYNC1;
         end else begin
            case (phase_ff)
               PH_SYNC2: begin
                  phase_in = (req_ch.rx_byte == sync_value) ? PH_HEADER : PH_SYNC1;
               end
               PH_HEADER: begin
                  header_in = req_ch.rx_byte;
                  sum_in    = req_ch.rx_byte;
                  phase_in  = PH_LENGTH;
               end
               PH_LENGTH: begin
                  if (len_ok) begin
                     length_in = req_ch.rx_byte[IDX_W-1:0];
                     sum_in    = add_mod255(sum_ff, req_ch.rx_byte);
                     count_in  = '0;
                     phase_in  = (req_ch.rx_byte != 8'd0) ? PH_DATA : PH_CHECK;
                  end else begin
                     phase_in = PH_SYNC1;
                  end
               end
               PH_DATA: begin
                  store_wr.en = 1'b1;
                  sum_in      = add_mod255(sum_ff, req_ch.rx_byte);
                  count_in    = count_ff + IDX_W'(1);
                  if (count_in >= length_ff) begin
                     phase_in = PH_CHECK;
                  end
               end
               PH_CHECK: begin
                  // good checksum hands the bank to the drain side
                  if (sum_ff == req_ch.rx_byte) begin
                     push    = 1'b1;
                     bank_in = !bank_ff;
                  end
                  phase_in = PH_SYNC1;
               end
               default: begin
                  phase_in = (req_ch.rx_byte == sync_value) ? PH_SYNC2 : PH_SYNC1;
               end
            endcase
         end
      end
   end

endmodule

// ===== rtl/core/sfpr_queue.sv =====
`include "sync_framed_packet_receiver_assert.svh"
// short queue of committed packets between parser and drain
module sfpr_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sfpr_pkg::desc_type push_desc,
   input  logic               pop,
   output sfpr_pkg::desc_type head,
   output logic               head_valid,
   output logic               full
);
   import sfpr_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   desc_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign head       = entry_ff[rd_ptr_ff];
   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

   // pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // parser must hold off while both banks are owned by the drain side
   `SFPR_ASSERT_IMP(a_no_push_full, push, !full, "packet committed into a full queue")
   `SFPR_ASSERT_IMP(a_no_pop_empty, pop, head_valid, "pop from an empty queue")
   `SFPR_ASSERT_IMP(a_count_range, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH), "queue count overflow")
   `SFPR_ASSERT_NXT(a_count_up, push && !pop, count_ff == $past(count_ff) + CNT_W'(1),
                    "queue count did not follow a push")

endmodule

// ===== rtl/core/sfpr_back.sv =====
`include "sync_framed_packet_receiver_assert.svh"
// drain engine: two-bank payload store, read stage and result register
module sfpr_back (
   input  logic                   clock,
   input  logic                   reset,
   sfpr_rsp_if.source             rsp_ch,
   input  sfpr_pkg::store_wr_type store_wr,
   input  sfpr_pkg::desc_type     head,
   input  logic                   head_valid,
   output logic                   pop
);
   import sfpr_pkg::*;

   localparam int MEM_DEPTH = 2 << IDX_W;

   logic [7:0]       store_mem [MEM_DEPTH];
   logic [7:0]       rd_data_ff;
   logic [IDX_W-1:0] k_ff, k_in;
   logic             s1_valid_ff, s1_valid_in;
   rsp_meta_type     s1_meta_ff;
   logic             out_valid_ff, out_valid_in;
   rsp_meta_type     out_meta_ff;
   logic [7:0]       out_byte_ff;
   logic             out_take;
   logic             s1_free;
   logic             issue;
   logic             last_issue;

   // handshake of the two stages
   assign out_take   = !out_valid_ff || rsp_ch.ready;
   assign s1_free    = !s1_valid_ff || out_take;
   assign issue      = head_valid && s1_free;
   assign last_issue = (head.length == '0) || (k_ff + IDX_W'(1) == head.length);
   assign pop        = issue && last_issue;

   // payload store, registered read
   always_ff @(posedge clock) begin
      if (store_wr.en) begin
         store_mem[{store_wr.bank, store_wr.index}] <= store_wr.data;
      end
      if (issue) begin
         rd_data_ff <= store_mem[{head.bank, k_ff}];
      end
   end

   // byte walk and valid bits
   always_comb begin
      k_in = k_ff;
      if (issue) begin
         k_in = last_issue ? '0 : k_ff + IDX_W'(1);
      end
      s1_valid_in  = issue ? 1'b1 : (out_take ? 1'b0 : s1_valid_ff);
      out_valid_in = out_take ? s1_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff         <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         k_ff         <= k_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // read stage and result register payload
   always_ff @(posedge clock) begin
      if (issue) begin
         s1_meta_ff <= '{header: head.header, length: head.length, pos: k_ff,
                         has: (head.length != '0), last: last_issue};
      end
      if (out_take && s1_valid_ff) begin
         out_meta_ff <= s1_meta_ff;
         out_byte_ff <= s1_meta_ff.has ? rd_data_ff : 8'd0;
      end
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.header_byte    = out_meta_ff.header;
   assign rsp_ch.payload_length = out_meta_ff.length;
   assign rsp_ch.byte_position  = out_meta_ff.pos;
   assign rsp_ch.payload_byte   = out_byte_ff;
   assign rsp_ch.has_payload    = out_meta_ff.has;
   assign rsp_ch.last_of_packet = out_meta_ff.last;

   `SFPR_ASSERT_IMP(a_issue_needs_head, issue, head_valid, "store read without a packet")
   `SFPR_ASSERT_NXT(a_s1_hold, s1_valid_ff && !out_take, s1_valid_ff,
                    "read stage lost a word while stalled")
   `SFPR_ASSERT_NXT(a_walk_step, issue && !last_issue, k_ff == $past(k_ff) + IDX_W'(1),
                    "byte walk skipped a position")

endmodule

// ===== tb/tb_top.sv =====
// testbench for the double-sync packet deframer: framed traffic against a software parser
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sfpr_pkg::*;

   localparam int LEN_LIMIT = PAYLOAD_LIMIT_DEFAULT;
   localparam int DRAIN_CYCLES = 12;
   localparam int unsigned CYCLE_LIMIT = 200000;

   // one result word as the block should present it
   typedef struct packed {
      logic [7:0] header;
      logic [4:0] length;
      logic [4:0] pos;
      logic [7:0] data;
      logic       has;
      logic       last;
   } out_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sfpr_req_if req_bus();
   sfpr_rsp_if rsp_bus();
   sfpr_csr_if csr_bus();

   sync_framed_packet_receiver #(
      .PAYLOAD_LIMIT(LEN_LIMIT)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // parser state mirrored in the testbench
   logic [7:0] sync_val;
   phase_type  phase;
   logic [7:0] hdr_hold;
   logic [4:0] len_hold;
   logic [4:0] byte_cnt;
   logic [7:0] run_sum;
   logic [7:0] payload_copy [0:STORE_DEPTH-1];

   out_word_type due_words[$];
   logic [7:0]   frame_buf[$];
   int unsigned  words_sent = 0;
   int unsigned  fail_count = 0;
   int unsigned  cycle_count = 0;
   int unsigned  snd_idle_pct = 0;
   int unsigned  rcv_idle_pct = 0;

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // receiver stalls at random
   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   function automatic logic [7:0] add255(logic [7:0] a, logic [7:0] b);
      int s;
      s = (int'(a) + int'(b)) % 255;
      return s[7:0];
   endfunction

   // checksum over header, length and payload of the frame in frame_buf
   function automatic logic [7:0] frame_checksum();
      logic [7:0] s;
      s = frame_buf[2];
      for (int i = 3; i < frame_buf.size() - 1; i++) begin
         s = add255(s, frame_buf[i]);
      end
      return s;
   endfunction

   // advance the mirrored parser by one accepted word, queue the words it emits
   task automatic parse_word(op_type op, logic [7:0] b);
      if (op == OP_TIMEOUT) begin
         phase = PH_SYNC1;
         return;
      end
      case (phase)
         PH_SYNC2: begin
            phase = (b == sync_val) ? PH_HEADER : PH_SYNC1;
         end
         PH_HEADER: begin
            hdr_hold = b;
            run_sum = b;
            phase = PH_LENGTH;
         end
         PH_LENGTH: begin
            if (b < LEN_LIMIT && b <= STORE_DEPTH) begin
               len_hold = b[4:0];
               run_sum = add255(run_sum, b);
               byte_cnt = '0;
               phase = (b != 8'd0) ? PH_DATA : PH_CHECK;
            end else begin
               phase = PH_SYNC1;
            end
         end
         PH_DATA: begin
            payload_copy[byte_cnt] = b;
            run_sum = add255(run_sum, b);
            byte_cnt = byte_cnt + 5'd1;
            if (byte_cnt >= len_hold) begin
               phase = PH_CHECK;
            end
         end
         PH_CHECK: begin
            if (run_sum == b) begin
               if (len_hold == 5'd0) begin
                  due_words.push_back(out_word_type'{hdr_hold, len_hold, 5'd0, 8'd0,
                                                     1'b0, 1'b1});
               end else begin
                  for (int k = 0; k < len_hold; k++) begin
                     due_words.push_back(out_word_type'{hdr_hold, len_hold, 5'(k),
                                                        payload_copy[k], 1'b1,
                                                        (k + 1 == int'(len_hold))});
                  end
               end
            end
            phase = PH_SYNC1;
         end
         default: begin
            phase = (b == sync_val) ? PH_SYNC2 : PH_SYNC1;
         end
      endcase
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // compare each result word with the oldest one due
   always @(posedge clock) begin : compare_out
      out_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (due_words.size() == 0) begin
            $display("%0t: result word expected none, actual hdr %0h len %0d pos %0d byte %0h",
                     $time, rsp_bus.header_byte, rsp_bus.payload_length,
                     rsp_bus.byte_position, rsp_bus.payload_byte);
            fail_count++;
         end else begin
            want = due_words.pop_front();
            check_field("header_byte", want.header, rsp_bus.header_byte);
            check_field("payload_length", want.length, rsp_bus.payload_length);
            check_field("byte_position", want.pos, rsp_bus.byte_position);
            check_field("payload_byte", want.data, rsp_bus.payload_byte);
            check_field("has_payload", want.has, rsp_bus.has_payload);
            check_field("last_of_packet", want.last, rsp_bus.last_of_packet);
         end
      end
   end

   // one input word, with random idle cycles ahead of it
   task automatic send_word(op_type op, logic [7:0] b);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.operation <= op;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      parse_word(op, b);
      words_sent++;
   endtask

   task automatic send_frame();
      foreach (frame_buf[i]) begin
         send_word(OP_BYTE, frame_buf[i]);
      end
   endtask

   // sync, sync, header, length, random payload, good checksum
   task automatic build_frame(logic [7:0] hdr, int unsigned n);
      frame_buf = {sync_val, sync_val, hdr, 8'(n)};
      repeat (n) frame_buf.push_back(8'($urandom));
      frame_buf.push_back(8'd0);
      frame_buf[frame_buf.size() - 1] = frame_checksum();
   endtask

   // hold input off until every due word is out, then let the block settle
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (due_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_sync_value(logic [7:0] v);
      csr_bus.valid <= 1'b1;
      csr_bus.sync_value <= v;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      sync_val = v;
   endtask

   // edge cases at the reset sync value
   task automatic test_directed_frames();
      // empty packet, all-zero header
      build_frame(8'h00, 0);
      send_frame();
      // one payload byte, header and payload at all ones
      build_frame(8'hFF, 1);
      frame_buf[4] = 8'hFF;
      frame_buf[5] = frame_checksum();
      send_frame();
      // wrong checksum drops the packet
      build_frame(8'h12, 0);
      frame_buf[4] = frame_buf[4] + 8'd1;
      send_frame();
      // checksum of all ones never matches
      build_frame(8'hFF, 0);
      frame_buf[4] = 8'hFF;
      send_frame();
      // length at the limit resyncs
      frame_buf = {sync_val, sync_val, 8'h34, 8'(LEN_LIMIT)};
      send_frame();
      // timeout right after the header
      build_frame(8'h77, 3);
      while (frame_buf.size() > 3) void'(frame_buf.pop_back());
      send_frame();
      send_word(OP_TIMEOUT, 8'hFF);
   endtask

   // mostly good frames with random content, plus broken frames and noise
   task automatic test_random_traffic(int unsigned n_words);
      int unsigned stop_at;
      int unsigned pick;
      int unsigned len;
      int unsigned cut;
      stop_at = words_sent + n_words;
      while (words_sent < stop_at) begin
         pick = $urandom_range(99);
         cut = $urandom_range(9);
         len = (cut < 6) ? $urandom_range(6) : (cut < 9) ? $urandom_range(31) : 31;
         if ($urandom_range(3) == 0) begin
            send_word(OP_TIMEOUT, 8'($urandom));
         end
         if (pick < 70) begin
            build_frame(8'($urandom), len);
            send_frame();
         end else if (pick < 80) begin
            // corrupted checksum
            build_frame(8'($urandom), len);
            frame_buf[frame_buf.size() - 1] =
               frame_buf[frame_buf.size() - 1] + 8'($urandom_range(1, 255));
            send_frame();
         end else if (pick < 88) begin
            // frame cut short by a timeout
            build_frame(8'($urandom), len);
            cut = $urandom_range(1, frame_buf.size() - 1);
            while (frame_buf.size() > cut) void'(frame_buf.pop_back());
            send_frame();
            send_word(OP_TIMEOUT, 8'($urandom));
         end else if (pick < 93) begin
            // oversized length
            frame_buf = {sync_val, sync_val, 8'($urandom),
                         8'($urandom_range(LEN_LIMIT, 255))};
            send_frame();
         end else begin
            // loose words, half of the bytes at the sync value
            repeat ($urandom_range(1, 3)) begin
               send_word(op_type'($urandom_range(1)),
                         ($urandom_range(1) == 1) ? sync_val : 8'($urandom));
            end
         end
      end
   endtask

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.operation <= OP_BYTE;
      req_bus.rx_byte <= 8'd0;
      csr_bus.valid <= 1'b0;
      csr_bus.sync_value <= 8'd0;
      sync_val = SYNC_RESET;
      phase = PH_SYNC1;
      hdr_hold = '0;
      len_hold = '0;
      byte_cnt = '0;
      run_sum = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      snd_idle_pct = 24;
      rcv_idle_pct = 53;
      test_directed_frames();
      wait_drained();
      write_sync_value(8'h00);
      test_random_traffic(150);

      wait_drained();
      snd_idle_pct = 53;
      rcv_idle_pct = 24;
      write_sync_value(8'hFF);
      test_random_traffic(150);

      wait_drained();
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      write_sync_value(8'($urandom_range(1, 254)));
      test_random_traffic(80);

      wait_drained();
      write_sync_value(SYNC_RESET);
      test_random_traffic(80);
      wait_drained();

      if (fail_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
